// File: sv/decimated_difference_moving_average_defines.svh
// assertion macros for the decimated difference moving average
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef DECIMATED_DIFFERENCE_MOVING_AVERAGE_DEFINES_SVH
`define DECIMATED_DIFFERENCE_MOVING_AVERAGE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DDMA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DDMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DDMA_ASSERT(lbl, clk, rst, prop, msg)
`define DDMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: sv/ddma_pkg.sv
// package for the decimated difference moving average
// window geometry, register indexes and sequencer states; no dependencies
package ddma_pkg;

  localparam int DEPTH_LOG2   = 4;
  localparam int WINDOW_DEPTH = 1 << DEPTH_LOG2;
  localparam int SUM_W        = 8 + DEPTH_LOG2;

  localparam logic [1:0] REG_TICK_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_DIFFERENCE_GAIN = 2'd1;
  localparam logic [1:0] REG_OUTPUT_GAIN     = 2'd2;

  localparam logic [15:0] TICK_INTERVAL_RESET   = 16'd15;
  localparam logic [6:0]  DIFFERENCE_GAIN_RESET = 7'd1;
  localparam logic [6:0]  OUTPUT_GAIN_RESET     = 7'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FINISH
  } state_t;

endpackage

// File: sv/decimated_difference_moving_average.sv
// An input transfer moves the sequencer through S_CALC and S_FINISH; the result is
// registered into level when S_FINISH finds the output free. in_ready is low in
// S_CALC, so a new transfer waits for the read-modify-write of the window memory.
// Reset: synchronous; configuration and control registers return to defaults and
// window entry valid bits clear, so empty entries read as zero with no clearing pass.
`include "decimated_difference_moving_average_defines.svh"

module decimated_difference_moving_average
  import ddma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [7:0]  level,
  output logic               updated
);

  logic [15:0] tick_interval;
  logic [6:0]  difference_gain;
  logic [6:0]  output_gain;

  state_t state, state_next;

  logic [DEPTH_LOG2-1:0]   write_slot;
  logic [15:0]             skip_count;
  logic [7:0]              previous_sample;
  logic signed [7:0]       mean_value;
  logic signed [SUM_W-1:0] window_sum;
  logic [WINDOW_DEPTH-1:0] entry_valid;

  logic [7:0] window_mem [WINDOW_DEPTH];
  logic [7:0] rd_data;
  logic       old_valid;
  logic       used;
  logic [7:0] diff;

  logic accept, out_free, out_load;
  logic use_now;

  logic signed [7:0]       old_val;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] biased;
  logic signed [15:0]      product;
  logic signed [7:0]       level_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_interval   <= TICK_INTERVAL_RESET;
      difference_gain <= DIFFERENCE_GAIN_RESET;
      output_gain     <= OUTPUT_GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TICK_INTERVAL:   tick_interval   <= cfg_data;
        REG_DIFFERENCE_GAIN: difference_gain <= cfg_data[6:0];
        REG_OUTPUT_GAIN:     output_gain     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CALC;
      S_CALC:   state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = in_valid ? S_CALC : S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE:   in_ready = 1'b1;
      S_CALC:   ;
      S_FINISH: begin
        in_ready = out_free;
        out_load = out_free;
      end
      default:  ;
    endcase
  end

  assign accept  = in_valid && in_ready;
  assign use_now = skip_count >= tick_interval;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // decimation and difference at the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count      <= '0;
      previous_sample <= '0;
      used            <= 1'b0;
    end else if (accept) begin
      used <= use_now;
      if (use_now) begin
        skip_count      <= '0;
        previous_sample <= sample;
      end else begin
        skip_count <= skip_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff      <= 8'((previous_sample - sample) * difference_gain);
      old_valid <= entry_valid[write_slot];
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (accept) rd_data <= window_mem[write_slot];
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC && used) window_mem[write_slot] <= diff;
  end

  // running sum and mean
  always_comb begin
    old_val  = old_valid ? $signed(rd_data) : 8'sd0;
    sum_next = window_sum - SUM_W'(old_val) + SUM_W'($signed(diff));
    biased   = sum_next + (sum_next[SUM_W-1] ? SUM_W'(WINDOW_DEPTH - 1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      window_sum  <= '0;
      mean_value  <= '0;
      entry_valid <= '0;
    end else if (state == S_CALC && used) begin
      write_slot              <= write_slot + 1'b1;
      window_sum              <= sum_next;
      mean_value              <= biased[SUM_W-1:DEPTH_LOG2];
      entry_valid[write_slot] <= 1'b1;
    end
  end

  // output gain and saturation
  always_comb begin
    product = mean_value * $signed({1'b0, output_gain});
    if (product > 16'sd127)       level_next = 8'sd127;
    else if (product < -16'sd128) level_next = -8'sd128;
    else                          level_next = product[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst)                       out_valid <= 1'b0;
    else if (out_load)             out_valid <= 1'b1;
    else if (out_valid && out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level   <= level_next;
      updated <= used;
    end
  end

  `DDMA_ASSERT_NEXT(a_accept_calc, clk, rst, accept, state == S_CALC, "transfer not followed by calc")
  `DDMA_ASSERT_NEXT(a_calc_finish, clk, rst, state == S_CALC, state == S_FINISH, "calc not followed by finish")
  `DDMA_ASSERT_NEXT(a_slot_step, clk, rst, state == S_CALC && used, write_slot == DEPTH_LOG2'($past(write_slot) + 1'b1), "write slot did not advance")
  `DDMA_ASSERT_NEXT(a_load_valid, clk, rst, out_load, out_valid, "result not presented after load")
  `DDMA_ASSERT(a_ready_state, clk, rst, !in_ready || state == S_IDLE || state == S_FINISH, "ready during calc")

endmodule
